### rtl/ddarc_pkg.sv
// ----------------------------------------------------------------------------
// DDA ray caster package
// Shared constants, datapath command codes and the command and status structs.
// ----------------------------------------------------------------------------
package ddarc_pkg;

  localparam int MapSize      = 64;
  localparam int MapAw        = 12;
  localparam int ScreenWidth  = 320;
  localparam int ScreenHeight = 240;
  localparam int MaxSteps     = 128;
  localparam int HalfHeight   = ScreenHeight / 2;

  // Camera coordinate scale: (column << 17) / ScreenWidth is taken as
  // (column * CamRecip) >> CamShift, exact over the whole column range.
  localparam int CamShift = 13;
  localparam int CamRecip = ((1 << (17 + CamShift)) + ScreenWidth - 1) / ScreenWidth;

  localparam int NumW  = 33;
  localparam int DenW  = 24;
  localparam int RayW  = 20;
  localparam int SideW = 48;

  // Configuration register indexes.
  localparam logic [2:0] RegPosX   = 3'd0;
  localparam logic [2:0] RegPosY   = 3'd1;
  localparam logic [2:0] RegDirX   = 3'd2;
  localparam logic [2:0] RegDirY   = 3'd3;
  localparam logic [2:0] RegPlaneX = 3'd4;
  localparam logic [2:0] RegPlaneY = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WRITE,
    OP_LOAD,
    OP_RAY_MUL,
    OP_RAY_ADD,
    OP_DX_START,
    OP_DX_TAKE,
    OP_DY_TAKE,
    OP_SIDE,
    OP_STEP,
    OP_PERP,
    OP_WALL,
    OP_TEX,
    OP_EMIT_HIT,
    OP_EMIT_MISS
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clear_last;
    logic wall_found;
    logic escaped;
  } status_t;

endpackage

### rtl/ddarc_div.sv
// ----------------------------------------------------------------------------
// DDA ray caster divider
// Restoring divider, one quotient bit per cycle; a start during a division restarts it.
// ----------------------------------------------------------------------------
module ddarc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ddarc_pkg::NumW-1:0] num,
  input  logic [ddarc_pkg::DenW-1:0] den,
  output logic [ddarc_pkg::NumW-1:0] quo,
  output logic                       done
);
  import ddarc_pkg::*;

  localparam int CntW = $clog2(NumW);

  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem;
  logic [CntW-1:0] cnt;
  logic            active;
  logic [DenW:0]   rs;
  logic            ge;

  assign rs = {rem, quo[NumW-1]};
  assign ge = rs >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        quo    <= num;
        den_q  <= den;
        rem    <= '0;
      end else if (active) begin
        rem <= ge ? DenW'(rs - {1'b0, den_q}) : rs[DenW-1:0];
        quo <= {quo[NumW-2:0], ge};
        if (cnt == CntW'(NumW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

### rtl/ddarc_dp.sv
// ----------------------------------------------------------------------------
// DDA ray caster datapath
// Camera registers, map store, ray set-up, grid walk and result registers.
// ----------------------------------------------------------------------------
module ddarc_dp (
  input  logic                clk,
  input  logic                rst,
  input  ddarc_pkg::cmd_t     cmd,
  output ddarc_pkg::status_t  status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [21:0]         cfg_data,
  input  logic [5:0]          cell_x,
  input  logic [5:0]          cell_y,
  input  logic [7:0]          cell_value,
  input  logic [8:0]          column,
  output logic                done,
  output logic [8:0]          column_out,
  output logic                hit,
  output logic                side,
  output logic [23:0]         wall_distance,
  output logic [7:0]          texture_index,
  output logic [5:0]          tex_column,
  output logic [15:0]         line_height,
  output logic [7:0]          draw_start,
  output logic [7:0]          draw_end
);
  import ddarc_pkg::*;

  logic [21:0] pos_x, pos_y;
  logic signed [17:0] dir_x, dir_y, plane_x, plane_y;

  logic [7:0] map_mem [1 << MapAw];
  logic [7:0] rd_q;
  logic [MapAw-1:0] clr_addr;

  logic [8:0] col;
  logic signed [18:0] cam;
  logic signed [36:0] px, py;
  logic signed [RayW-1:0] ray_x, ray_y;
  logic [31:0] dx, dy;
  logic [SideW-1:0] sdx, sdy;
  logic signed [7:0] map_x, map_y;
  logic [7:0] steps;
  logic [31:0] perp;
  logic [23:0] depth;
  logic signed [52:0] wprod;
  logic [5:0] tex;

  logic div_start;
  logic [NumW-1:0] div_num, div_q;
  logic [DenW-1:0] div_den;
  logic div_done;

  logic [30:0] cam_scaled;
  logic signed [20:0] ray_x_sum, ray_y_sum;
  logic [16:0] fsel_x, fsel_y;
  logic go_x;
  logic signed [7:0] nx, ny;
  logic [SideW-1:0] perp_full;
  logic [15:0] frac;
  logic [5:0] tex_raw;
  logic mirror;
  logic [15:0] lh;
  logic [14:0] half;
  logic out_map;

  ddarc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  assign cam_scaled = 31'(column) * 31'(CamRecip);
  assign ray_x_sum = 21'(dir_x) + 21'(px >>> 16);
  assign ray_y_sum = 21'(dir_y) + 21'(py >>> 16);
  assign fsel_x    = ray_x[RayW-1] ? {1'b0, pos_x[15:0]} : 17'h10000 - {1'b0, pos_x[15:0]};
  assign fsel_y    = ray_y[RayW-1] ? {1'b0, pos_y[15:0]} : 17'h10000 - {1'b0, pos_y[15:0]};
  assign go_x      = sdx < sdy;
  assign nx        = ray_x[RayW-1] ? map_x - 8'sd1 : map_x + 8'sd1;
  assign ny        = ray_y[RayW-1] ? map_y - 8'sd1 : map_y + 8'sd1;
  assign perp_full = side ? sdy - SideW'(dy) : sdx - SideW'(dx);
  assign frac      = side ? 16'(pos_x[15:0] + wprod[31:16])
                          : 16'(pos_y[15:0] + wprod[31:16]);
  assign tex_raw   = frac[15:10];
  assign mirror    = (!side && !ray_x[RayW-1] && ray_x != '0) || (side && ray_y[RayW-1]);
  assign lh        = (div_q[NumW-1:16] != '0) ? 16'hFFFF : div_q[15:0];
  assign half      = lh[15:1];
  assign out_map   = (map_x[7:6] != 2'b00) || (map_y[7:6] != 2'b00);

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_DX_START: begin
        div_start = 1'b1;
        div_num   = NumW'(1) << 32;
        div_den   = DenW'(ray_x[RayW-1] ? -ray_x : ray_x);
      end
      OP_DX_TAKE: begin
        div_start = 1'b1;
        div_num   = NumW'(1) << 32;
        div_den   = DenW'(ray_y[RayW-1] ? -ray_y : ray_y);
      end
      OP_WALL: begin
        div_start = 1'b1;
        div_num   = NumW'(ScreenHeight) << 16;
        div_den   = depth;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Map store: one write port shared by clearing and cell writes, one read port.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) begin
      map_mem[clr_addr] <= 8'd0;
    end else if (cmd.op == OP_WRITE) begin
      map_mem[{cell_y, cell_x}] <= cell_value;
    end
    if (cmd.op == OP_STEP) begin
      rd_q <= go_x ? map_mem[{map_y[5:0], nx[5:0]}] : map_mem[{ny[5:0], map_x[5:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 22'd98304;
      pos_y   <= 22'd98304;
      dir_x   <= 18'sd65536;
      dir_y   <= 18'sd0;
      plane_x <= 18'sd0;
      plane_y <= 18'sd43253;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPosX:   pos_x   <= cfg_data;
        RegPosY:   pos_y   <= cfg_data;
        RegDirX:   dir_x   <= cfg_data[17:0];
        RegDirY:   dir_y   <= cfg_data[17:0];
        RegPlaneX: plane_x <= cfg_data[17:0];
        RegPlaneY: plane_y <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_EMIT_HIT) || (cmd.op == OP_EMIT_MISS);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        col <= column;
        cam <= $signed({1'b0, cam_scaled[CamShift+17:CamShift]}) - 19'sd65536;
      end
      OP_RAY_MUL: begin
        px <= plane_x * cam;
        py <= plane_y * cam;
      end
      OP_RAY_ADD: begin
        ray_x <= ray_x_sum[RayW-1:0];
        ray_y <= ray_y_sum[RayW-1:0];
      end
      OP_DX_TAKE: dx <= div_q[32] ? 32'hFFFF_FFFF : div_q[31:0];
      OP_DY_TAKE: dy <= div_q[32] ? 32'hFFFF_FFFF : div_q[31:0];
      OP_SIDE: begin
        sdx   <= (SideW'(fsel_x) * SideW'(dx)) >> 16;
        sdy   <= (SideW'(fsel_y) * SideW'(dy)) >> 16;
        map_x <= {2'b00, pos_x[21:16]};
        map_y <= {2'b00, pos_y[21:16]};
        steps <= '0;
      end
      OP_STEP: begin
        steps <= steps + 1'b1;
        if (go_x) begin
          sdx   <= sdx + SideW'(dx);
          map_x <= nx;
          side  <= 1'b0;
        end else begin
          sdy   <= sdy + SideW'(dy);
          map_y <= ny;
          side  <= 1'b1;
        end
      end
      OP_PERP: begin
        perp  <= (perp_full[SideW-1:32] != '0) ? 32'hFFFF_FFFF : perp_full[31:0];
        depth <= ((perp_full[SideW-1:32] != '0) || (perp_full[31:24] != '0))
                 ? 24'hFF_FFFF : perp_full[23:0];
      end
      OP_WALL: wprod <= $signed({1'b0, perp}) * (side ? ray_x : ray_y);
      OP_TEX:  tex <= mirror ? ~tex_raw : tex_raw;
      OP_EMIT_HIT: begin
        column_out    <= col;
        hit           <= 1'b1;
        wall_distance <= depth;
        texture_index <= rd_q - 8'd1;
        tex_column    <= tex;
        line_height   <= lh;
        draw_start    <= (half > 15'(HalfHeight)) ? 8'd0 : 8'(15'(HalfHeight) - half);
        draw_end      <= (half >= 15'(ScreenHeight - 1 - HalfHeight))
                         ? 8'(ScreenHeight - 1) : 8'(15'(HalfHeight) + half);
      end
      OP_EMIT_MISS: begin
        column_out    <= col;
        hit           <= 1'b0;
        wall_distance <= 24'hFF_FFFF;
        texture_index <= 8'd0;
        tex_column    <= 6'd0;
        line_height   <= 16'd0;
        draw_start    <= 8'(HalfHeight);
        draw_end      <= 8'(HalfHeight);
      end
      default: ;
    endcase
  end

  always_comb begin
    status.div_done   = div_done;
    status.clear_last = &clr_addr;
    status.wall_found = !out_map && rd_q != 8'd0;
    status.escaped    = out_map || (rd_q == 8'd0 && steps == 8'(MaxSteps));
  end

endmodule

### rtl/ddarc_ctrl.sv
// ----------------------------------------------------------------------------
// DDA ray caster controller
// Sequences the map clearing pass, cell writes and the phases of one cast.
// ----------------------------------------------------------------------------
module ddarc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               func,
  input  ddarc_pkg::status_t status,
  output ddarc_pkg::cmd_t    cmd,
  output logic               busy
);
  import ddarc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RAY_MUL, S_RAY_ADD, S_DX_START, S_DX_WAIT,
    S_DY_WAIT, S_SIDE, S_STEP, S_LOOK, S_PERP, S_WALL, S_TEX, S_LH_WAIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (func) begin
            cmd.op     = OP_LOAD;
            state_next = S_RAY_MUL;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      S_RAY_MUL: begin
        cmd.op     = OP_RAY_MUL;
        state_next = S_RAY_ADD;
      end
      S_RAY_ADD: begin
        cmd.op     = OP_RAY_ADD;
        state_next = S_DX_START;
      end
      S_DX_START: begin
        cmd.op     = OP_DX_START;
        state_next = S_DX_WAIT;
      end
      S_DX_WAIT: if (status.div_done) begin
        cmd.op     = OP_DX_TAKE;
        state_next = S_DY_WAIT;
      end
      S_DY_WAIT: if (status.div_done) begin
        cmd.op     = OP_DY_TAKE;
        state_next = S_SIDE;
      end
      S_SIDE: begin
        cmd.op     = OP_SIDE;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.op     = OP_STEP;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        if (status.wall_found) begin
          state_next = S_PERP;
        end else if (status.escaped) begin
          cmd.op     = OP_EMIT_MISS;
          state_next = S_IDLE;
        end else begin
          state_next = S_STEP;
        end
      end
      S_PERP: begin
        cmd.op     = OP_PERP;
        state_next = S_WALL;
      end
      S_WALL: begin
        cmd.op     = OP_WALL;
        state_next = S_TEX;
      end
      S_TEX: begin
        cmd.op     = OP_TEX;
        state_next = S_LH_WAIT;
      end
      S_LH_WAIT: if (status.div_done) begin
        cmd.op     = OP_EMIT_HIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

### rtl/dda_wall_ray_caster.sv
// ----------------------------------------------------------------------------
// DDA wall ray caster, top level
// Walks a 64 x 64 grid map for one screen column per command.
// ----------------------------------------------------------------------------
// Usage. An item is transferred when start is high and busy is low. With func
// at zero it writes one map cell and completes in that cycle; with func at one
// it casts the ray of the given screen column. The camera registers are written
// through the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data), which is
// always ready; write them only while busy is low.
// Each cast yields one result, shown for exactly one cycle with done high; the
// receiver cannot stall it, so it must take every result as it comes.
// Course of a cast: the camera coordinate is a constant multiply in the
// transfer cycle, then the ray set-up and two reciprocals on the shared
// restoring divider; each grid step has a step state that moves and reads the
// map memory and a look state that tests the cell, for at most 128 steps; a
// hit then takes the line height on the same divider. Busy falls as the result
// is shown, so the next item may follow.
// The map memory has a single write port, so after reset a clearing pass
// zeroes all 4096 cells, one cell a cycle; busy stays high meanwhile and the
// camera registers return to their reset values at once.
// ----------------------------------------------------------------------------
module dda_wall_ray_caster (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [7:0]  cell_value,
  input  logic [8:0]  column,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  output logic        done,
  output logic [8:0]  column_out,
  output logic        hit,
  output logic        side,
  output logic [23:0] wall_distance,
  output logic [7:0]  texture_index,
  output logic [5:0]  tex_column,
  output logic [15:0] line_height,
  output logic [7:0]  draw_start,
  output logic [7:0]  draw_end
);
  import ddarc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    accept;

  // The configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;
  // The controller only acts on start while it is idle.
  assign accept = start && !busy;

  ddarc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ddarc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_value    (cell_value),
    .column        (column),
    .done          (done),
    .column_out    (column_out),
    .hit           (hit),
    .side          (side),
    .wall_distance (wall_distance),
    .texture_index (texture_index),
    .tex_column    (tex_column),
    .line_height   (line_height),
    .draw_start    (draw_start),
    .draw_end      (draw_end)
  );

  // A cast always takes many cycles, so two results never come back to back.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");

  // A cast keeps the block busy from the cycle after its transfer.
  assert property (@(posedge clk) disable iff (rst) (accept && func) |=> busy)
    else $error("cast transfer did not raise busy");

  // The result appears as the controller returns to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  // An escaped ray gives an empty span at the screen centre.
  assert property (@(posedge clk) disable iff (rst)
      (done && !hit) |-> (draw_start == draw_end && line_height == 16'd0))
    else $error("escaped ray with a nonempty span");

endmodule

### tb/ddarc_checker.sv
// ----------------------------------------------------------------------------
// Ray caster result checker
// Watches the item, configuration and result ports of the ray caster. It keeps
// its own copy of the map and the camera registers and predicts each cast. It
// then compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ddarc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        func,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [7:0]  cell_value,
  input  logic [8:0]  column,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  input  logic        done,
  input  logic [8:0]  column_out,
  input  logic        hit,
  input  logic        side,
  input  logic [23:0] wall_distance,
  input  logic [7:0]  texture_index,
  input  logic [5:0]  tex_column,
  input  logic [15:0] line_height,
  input  logic [7:0]  draw_start,
  input  logic [7:0]  draw_end,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ddarc_pkg::*;

  localparam int     TexSize  = 64;
  localparam longint DeltaMax = 64'h0000_0000_FFFF_FFFF;
  localparam longint DistMax  = 64'h0000_0000_00FF_FFFF;

  typedef struct packed {
    logic [8:0]  col;
    logic        hit;
    logic        side;
    logic [23:0] depth;
    logic [7:0]  tex_idx;
    logic [5:0]  tex_col;
    logic [15:0] height;
    logic [7:0]  span_lo;
    logic [7:0]  span_hi;
  } column_result_t;

  logic [7:0]         grid [MapSize*MapSize];
  logic [21:0]        cam_x, cam_y;
  logic signed [17:0] look_x, look_y, fov_x, fov_y;
  column_result_t     column_q [$];

  function automatic longint step_delta(input longint r);
    longint a;
    if (r == 0) return DeltaMax;
    a = (r < 0) ? -r : r;
    a = (64'sd1 <<< 32) / a;
    return (a > DeltaMax) ? DeltaMax : a;
  endfunction

  function automatic column_result_t cast_column(input logic [8:0] col);
    longint cam, rx, ry, mx, my, dx, dy, sdx, sdy, fx, fy;
    longint perp, wall, tex, lh, ds, de;
    logic [7:0] cell_val;
    logic sd, found, gone;
    int n;
    column_result_t r;
    cam = ((longint'(col) * 2) <<< 16) / ScreenWidth - 65536;
    rx = longint'(look_x) + ((longint'(fov_x) * cam) >>> 16);
    ry = longint'(look_y) + ((longint'(fov_y) * cam) >>> 16);
    mx = longint'(cam_x >> 16);
    my = longint'(cam_y >> 16);
    fx = longint'(cam_x[15:0]);
    fy = longint'(cam_y[15:0]);
    dx = step_delta(rx);
    dy = step_delta(ry);
    sdx = (((rx < 0) ? fx : 65536 - fx) * dx) >>> 16;
    sdy = (((ry < 0) ? fy : 65536 - fy) * dy) >>> 16;
    sd = 1'b0;
    found = 1'b0;
    gone = 1'b0;
    cell_val = '0;
    // The camera cell itself is skipped: the first test follows the first step.
    for (n = 0; n < MaxSteps && !found && !gone; n++) begin
      if (sdx < sdy) begin
        sdx += dx;
        mx += (rx < 0) ? -1 : 1;
        sd = 1'b0;
      end else begin
        sdy += dy;
        my += (ry < 0) ? -1 : 1;
        sd = 1'b1;
      end
      if (mx < 0 || my < 0 || mx >= MapSize || my >= MapSize) begin
        gone = 1'b1;
      end else begin
        cell_val = grid[my*MapSize + mx];
        found = (cell_val != 8'd0);
      end
    end
    r.col = col;
    r.hit = found;
    r.side = sd;
    if (!found) begin
      r.depth = '1;
      r.tex_idx = '0;
      r.tex_col = '0;
      r.height = '0;
      r.span_lo = 8'(HalfHeight);
      r.span_hi = 8'(HalfHeight);
      return r;
    end
    perp = sd ? sdy - dy : sdx - dx;
    if (perp > DeltaMax) perp = DeltaMax;
    if (!sd) wall = longint'(cam_y) + ((perp * ry) >>> 16);
    else     wall = longint'(cam_x) + ((perp * rx) >>> 16);
    tex = ((wall & 64'hFFFF) * TexSize) >>> 16;
    // Mirror the texture so it reads the same way from both faces of a wall.
    if ((!sd && rx > 0) || (sd && ry < 0)) tex = TexSize - 1 - tex;
    r.depth = 24'((perp > DistMax) ? DistMax : perp);
    if (r.depth == 24'd0) begin
      lh = 65535;
    end else begin
      lh = (longint'(ScreenHeight) <<< 16) / longint'(r.depth);
      if (lh > 65535) lh = 65535;
    end
    ds = HalfHeight - lh / 2;
    if (ds < 0) ds = 0;
    de = HalfHeight + lh / 2;
    if (de >= ScreenHeight) de = ScreenHeight - 1;
    r.tex_idx = cell_val - 8'd1;
    r.tex_col = 6'(tex);
    r.height = 16'(lh);
    r.span_lo = 8'(ds);
    r.span_hi = 8'(de);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    column_result_t want;
    if (rst) begin
      foreach (grid[i]) grid[i] = '0;
      cam_x = 22'd98304;
      cam_y = 22'd98304;
      look_x = 18'sd65536;
      look_y = 18'sd0;
      fov_x = 18'sd0;
      fov_y = 18'sd43253;
      column_q.delete();
    end else begin
      if (done) begin
        if (column_q.size() == 0) begin
          report("result with nothing outstanding, column", column_out, 0);
        end else begin
          want = column_q.pop_front();
          if (column_out != want.col) report("column_out", column_out, want.col);
          if (hit != want.hit) report("hit", hit, want.hit);
          if (side != want.side) report("side", side, want.side);
          if (wall_distance != want.depth) report("wall_distance", wall_distance, want.depth);
          if (texture_index != want.tex_idx)
            report("texture_index", texture_index, want.tex_idx);
          if (tex_column != want.tex_col) report("tex_column", tex_column, want.tex_col);
          if (line_height != want.height) report("line_height", line_height, want.height);
          if (draw_start != want.span_lo) report("draw_start", draw_start, want.span_lo);
          if (draw_end != want.span_hi) report("draw_end", draw_end, want.span_hi);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegPosX:   cam_x = cfg_data;
          RegPosY:   cam_y = cfg_data;
          RegDirX:   look_x = cfg_data[17:0];
          RegDirY:   look_y = cfg_data[17:0];
          RegPlaneX: fov_x = cfg_data[17:0];
          RegPlaneY: fov_y = cfg_data[17:0];
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        if (!func) grid[int'(cell_y)*MapSize + int'(cell_x)] = cell_value;
        else column_q.push_back(cast_column(column));
      end
    end
    pending = column_q.size();
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Ray caster testbench
// Writes map cells and casts columns under a series of camera settings, the
// extremes among them. A directed set comes first, then each phase has random
// traffic, gapped but in the last. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddarc_pkg::*;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncCast  = 1'b1;
  localparam int   NumPhases = 9;
  localparam int   PhaseItems = 140;

  logic        clk, rst, start, busy, func;
  logic [5:0]  cell_x, cell_y, tex_column;
  logic [7:0]  cell_value, texture_index, draw_start, draw_end;
  logic [8:0]  column, column_out;
  logic        cfg_valid, cfg_ready, done, hit, side;
  logic [2:0]  cfg_index;
  logic [21:0] cfg_data;
  logic [23:0] wall_distance;
  logic [15:0] line_height;
  int          errors, pending;
  bit          calm;

  dda_wall_ray_caster dut (.*);
  ddarc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A guard against a hung block: far beyond the slowest correct run.
  initial begin
    #25_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // One item transfer. The item is presented at a falling edge and held until
  // a rising edge at which busy is low; it is transferred at that edge.
  // Start is lowered only when the next call does not follow at once.
  task automatic send(input logic f, input logic [5:0] cx, input logic [5:0] cy,
                      input logic [7:0] v, input logic [8:0] col);
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    cell_x <= cx;
    cell_y <= cy;
    cell_value <= v;
    column <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Random gap after the transfer, none in the closing stretch of the run.
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
  endtask

  task automatic write_cell(input int cx, input int cy, input int v);
    send(FuncWrite, 6'(cx), 6'(cy), 8'(v), 9'($urandom));
  endtask

  task automatic cast(input int col);
    send(FuncCast, 6'($urandom), 6'($urandom), 8'($urandom), 9'(col));
  endtask

  // Let the block drain: every outstanding column returned and busy low.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 22'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_camera(input int px, input int py, input int dx, input int dy,
                            input int fx, input int fy);
    drain();
    set_reg(RegPosX, px);
    set_reg(RegPosY, py);
    set_reg(RegDirX, dx);
    set_reg(RegDirY, dy);
    set_reg(RegPlaneX, fx);
    set_reg(RegPlaneY, fy);
  endtask

  function automatic int rand_q2(input int lim);
    return int'($urandom_range(0, 2 * lim - 1)) - lim;
  endfunction

  task automatic random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        // Map writes, a quarter of them clearing a cell back to empty.
        write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                   ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
      end else begin
        // Mostly on-screen columns, with some beyond the right edge.
        cast(($urandom_range(0, 9) == 0) ? $urandom_range(320, 511)
                                         : $urandom_range(0, 319));
      end
    end
  endtask

  initial begin
    int p;
    rst = 1'b1;
    start = 1'b0;
    func = FuncWrite;
    cell_x = '0;
    cell_y = '0;
    cell_value = '0;
    column = '0;
    cfg_valid = 1'b0;
    cfg_index = RegPosX;
    cfg_data = '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset camera on an empty map: every ray escapes.
    cast(0);
    cast(160);
    cast(319);
    cast(511);
    // A wall in the camera cell must be ignored; the far wall uses texture 254.
    write_cell(1, 1, 9);
    write_cell(4, 1, 255);
    write_cell(63, 63, 1);
    write_cell(0, 0, 0);
    cast(160);
    cast(0);
    cast(319);
    cast(511);
    write_cell(2, 3, 128);
    write_cell(2, 0, 7);
    cast(40);
    cast(280);

    // Camera exactly on a cell boundary looking at the wall beside it gives
    // zero distance; a zero ray component saturates its step delta.
    set_camera(3 << 16, 98304, -65536, 0, 0, 0);
    write_cell(2, 1, 3);
    cast(160);
    cast(0);

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_camera(0, 0, -131072, -131072, 131071, 131071);
        1: set_camera(4194303, 4194303, 131071, 131071, -131072, -131072);
        2: set_camera(2129920, 2129920, 0, 0, 0, 0);
        3: set_camera(98304, 98304, 65536, 0, 0, 43253);
        default: set_camera($urandom_range(0, 4194303), $urandom_range(0, 4194303),
                            rand_q2(131072), rand_q2(131072),
                            rand_q2(131072), rand_q2(131072));
      endcase
      calm = (p == NumPhases - 1);
      random_traffic(PhaseItems);
    end

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
